FILE: rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the contact lifecycle tracker.
// Holds table size, field widths, event codes and the controller interface.
// ----------------------------------------------------------------------------
`default_nettype none
package clt_pkg;
  localparam int TableEntries = 16;
  localparam int ObjectIdBits = 16;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);

  localparam logic [2:0] EvEnter = 3'd0;
  localparam logic [2:0] EvStay  = 3'd1;
  localparam logic [2:0] EvExit  = 3'd2;
  localparam logic [2:0] EvDone  = 3'd3;
  localparam logic [2:0] EvDrop  = 3'd4;

  localparam logic RegGrace = 1'b0;
  localparam logic RegSkin  = 1'b1;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic        out_trigger;
    logic [15:0] out_first;
    logic [15:0] out_second;
    logic [15:0] eff_normal_x;
    logic [15:0] eff_normal_y;
    logic [15:0] eff_normal_z;
    logic        needs_resolution;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] first_object;
    logic [15:0] second_object;
    logic        is_trigger;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [23:0] separation;
  } item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;       // capture input item
    logic            report;     // perform report update and build result
    logic            clr_idx;    // restart the walk at slot zero
    logic            step;       // examine current slot during sweep
    logic            done;       // build sweep done result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic slot_exit;   // current slot holds an entry at zero countdown
    logic idx_last;    // current slot is the final slot
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/clt_stream_if.sv
// ----------------------------------------------------------------------------
// clt_stream_if: valid/ready channel carrying one payload.
// Used for the item, result and configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface clt_stream_if #(parameter int Width = 1);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/clt_datapath.sv
// ----------------------------------------------------------------------------
// clt_datapath: pair table, lookup, countdown update and result assembly.
// Executes the commands issued by the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module clt_datapath (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire clt_pkg::item_t   item_i,
  input  wire clt_pkg::cmd_t    cmd_i,
  input  wire                   cfg_we_i,
  input  wire                   cfg_idx_i,
  input  wire [22:0]            cfg_data_i,
  output clt_pkg::sts_t         sts_o,
  output clt_pkg::result_t      res_o
);
  localparam int N = clt_pkg::TableEntries;
  localparam int B = clt_pkg::ObjectIdBits;
  localparam int IdW = (B < 16) ? B : 16;

  logic [3:0]  grace_q;
  logic [22:0] skin_q;
  clt_pkg::item_t it_q;
  logic [N-1:0] valid_q;
  logic [B-1:0]  pa_q [N];
  logic [B-1:0]  pb_q [N];
  logic [47:0]   nrm_q [N];
  logic [3:0]    cnt_q [N];
  logic [N-1:0]  trg_q;
  logic [clt_pkg::IdxW-1:0] idx_q;
  clt_pkg::result_t res_q;
  clt_pkg::result_t res_d;

  logic [B-1:0] a, b;
  logic [N-1:0] hit_v;
  logic hit, fre;
  logic [clt_pkg::IdxW-1:0] hit_i, free_i;
  logic keep;
  logic [47:0] nin;

  always_comb begin
    a = B'(it_q.first_object[IdW-1:0]);
    b = B'(it_q.second_object[IdW-1:0]);
    nin = {it_q.normal_x, it_q.normal_y, it_q.normal_z};
    hit = 1'b0;
    fre = 1'b0;
    hit_i = '0;
    free_i = '0;
    for (int i = N - 1; i >= 0; i--) begin
      hit_v[i] = valid_q[i] && pa_q[i] == a && pb_q[i] == b;
      if (hit_v[i]) begin
        hit = 1'b1;
        hit_i = clt_pkg::IdxW'(i);
      end
      if (!valid_q[i]) begin
        fre = 1'b1;
        free_i = clt_pkg::IdxW'(i);
      end
    end
    keep = $signed(it_q.separation) < $signed({1'b0, skin_q});
  end

  assign sts_o.mode = it_q.mode;
  assign sts_o.slot_exit = valid_q[idx_q] && cnt_q[idx_q] == 4'd0;
  assign sts_o.idx_last = idx_q == clt_pkg::IdxW'(N - 1);
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= 4'd3;
      skin_q <= 23'd662;
      valid_q <= '0;
      idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == clt_pkg::RegGrace) grace_q <= cfg_data_i[3:0];
        else skin_q <= cfg_data_i;
      end
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.step) idx_q <= idx_q + 1'b1;
      if (cmd_i.report) begin
        if (hit) begin
          if (!keep) nrm_q[hit_i] <= nin;
          cnt_q[hit_i] <= grace_q;
          trg_q[hit_i] <= it_q.is_trigger;
        end else if (fre) begin
          valid_q[free_i] <= 1'b1;
          pa_q[free_i] <= a;
          pb_q[free_i] <= b;
          nrm_q[free_i] <= nin;
          cnt_q[free_i] <= grace_q;
          trg_q[free_i] <= it_q.is_trigger;
        end
      end
      if (cmd_i.step && valid_q[idx_q]) begin
        if (cnt_q[idx_q] == 4'd0) valid_q[idx_q] <= 1'b0;
        else cnt_q[idx_q] <= cnt_q[idx_q] - 4'd1;
      end
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.report) begin
      res_d = '0;
      res_d.out_trigger = it_q.is_trigger;
      res_d.out_first = 16'(a);
      res_d.out_second = 16'(b);
      res_d.last = 1'b1;
      if (hit || fre) begin
        res_d.event_kind = hit ? clt_pkg::EvStay : clt_pkg::EvEnter;
        {res_d.eff_normal_x, res_d.eff_normal_y, res_d.eff_normal_z} =
          (hit && keep) ? nrm_q[hit_i] : nin;
        res_d.needs_resolution = !it_q.is_trigger;
      end else begin
        res_d.event_kind = clt_pkg::EvDrop;
      end
    end else if (cmd_i.step) begin
      res_d = '0;
      res_d.event_kind = clt_pkg::EvExit;
      res_d.out_trigger = trg_q[idx_q];
      res_d.out_first = 16'(pa_q[idx_q]);
      res_d.out_second = 16'(pb_q[idx_q]);
    end else if (cmd_i.done) begin
      res_d = '0;
      res_d.event_kind = clt_pkg::EvDone;
      res_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    res_q <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.report |=> $countones(valid_q) >= $countones($past(valid_q)))
    else $error("report removed an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> $countones(valid_q) <= $countones($past(valid_q)))
    else $error("sweep added an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_v))
    else $error("duplicate pair in table");
endmodule
`default_nettype wire

FILE: rtl/clt_ctrl.sv
// ----------------------------------------------------------------------------
// clt_ctrl: sequencer for report and sweep items.
// Drives the datapath and the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module clt_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  input  wire clt_pkg::sts_t sts_i,
  output clt_pkg::cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StDecode, StScan, StOut, StDone
  } state_e;

  state_e state_q;
  logic   ov_q;
  logic   ov_d;
  logic   fin_q;

  wire free = !ov_q || out_ready_i;

  assign in_ready_o = state_q == StIdle;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    case (state_q)
      StDecode: begin
        cmd_o.report = !sts_i.mode && free;
        cmd_o.clr_idx = sts_i.mode;
      end
      StScan: cmd_o.step = free;
      StDone: cmd_o.done = free;
      default: ;
    endcase
  end

  assign ov_d = (cmd_o.report || (cmd_o.step && sts_i.slot_exit) || cmd_o.done) ? 1'b1 :
                (out_ready_i ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StDecode;
        StDecode: begin
          if (sts_i.mode) state_q <= StScan;
          else if (free) state_q <= StIdle;
        end
        StScan: if (free) begin
          state_q <= sts_i.idx_last ? StDone : StScan;
        end
        StDone: if (free) begin
          fin_q <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          fin_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.report || cmd_o.step || cmd_o.done) |-> (!ov_q || out_ready_i))
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> state_q == StOut)
    else $error("done flag out of place");
endmodule
`default_nettype wire

FILE: rtl/contact_lifecycle_tracker_core.sv
// ----------------------------------------------------------------------------
// contact_lifecycle_tracker_core: enter/stay/exit tracking of object pairs.
//
// Items arrive on item_if; results leave on result_if; registers are written
// on cfg_if (index 0 exit grace frames, index 1 skin threshold).
// A report's single result is registered from the decode state once the output
// register is free, and the next item is accepted after the return to idle.
// A sweep restarts the walk at slot zero in the decode state, walks the
// 16-entry table one slot a cycle while the output register is free, then
// emits the done result from the done state and passes a closing state
// before idle. The pair lookup matches all slots in parallel, combinationally.
// Results sit in an output register; when the receiver stalls, the walk holds
// until the register is taken, so nothing is lost. Reset clears all valid
// bits and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module contact_lifecycle_tracker_core (
  input  wire  clk_i,
  input  wire  rst_ni,
  clt_stream_if.sink   item_if,
  clt_stream_if.source result_if,
  clt_stream_if.sink   cfg_if
);
  clt_pkg::cmd_t    cmd;
  clt_pkg::sts_t    sts;
  clt_pkg::result_t res;

  assign cfg_if.ready = 1'b1;
  assign result_if.data = res;

  clt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (item_if.valid),
    .in_ready_o (item_if.ready),
    .out_valid_o(result_if.valid),
    .out_ready_i(result_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  clt_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i    (item_if.data),
    .cmd_i     (cmd),
    .cfg_we_i  (cfg_if.valid),
    .cfg_idx_i (cfg_if.data[23]),
    .cfg_data_i(cfg_if.data[22:0]),
    .sts_o     (sts),
    .res_o     (res)
  );
endmodule
`default_nettype wire
